// ----- rtl/core/tedc_pkg.sv -----
// Shared types and constants for the text escape decoder.
package tedc_pkg;

	localparam int MAX_LEN = 1024;
	localparam int CNT_W   = $clog2(MAX_LEN);
	localparam logic [CNT_W-1:0] LIMIT    = CNT_W'(MAX_LEN - 1);
	localparam logic [CNT_W-1:0] LIMIT_M1 = CNT_W'(MAX_LEN - 2);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_7     = 8'h37;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] HL_BIT   = 8'h80;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       final_result;
		logic       was_truncated;
	} out_item_t;

	// Classified item: up to two decoded bytes, plus the end-of-string mark.
	typedef struct packed {
		logic [1:0] nbytes;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic       last;
	} entry_t;

	typedef enum logic [5:0] {
		M_NORMAL = 6'b000001,
		M_ESC    = 6'b000010,
		M_HEX0   = 6'b000100,
		M_HEX1   = 6'b001000,
		M_OCT1   = 6'b010000,
		M_OCT2   = 6'b100000
	} mode_t;

endpackage

// ----- rtl/core/tedc_front.sv -----
// Front end: escape-sequence decoder producing classified entries.
module tedc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  tedc_pkg::in_item_t item,
	output logic               push,
	output tedc_pkg::entry_t   entry
);

	tedc_pkg::mode_t mode_q, nmode;
	logic [7:0] acc_q, nacc;
	logic       hl_q, nhl;

	logic [7:0] c;
	logic       last;
	logic [7:0] hl, nhl_bits;
	logic       is_oct, is_hex;
	logic [3:0] hexv;
	logic       pre_v, plain_v, end_v, do_plain;
	logic [7:0] pre_b, plain_b, end_b;
	logic [1:0] np;
	logic [7:0] b0, b1;

	assign c    = item.text_byte;
	assign last = item.end_of_string;
	assign hl   = hl_q ? tedc_pkg::HL_BIT : 8'h00;

	assign is_oct = (c >= tedc_pkg::CH_0) && (c <= tedc_pkg::CH_7);
	assign is_hex = ((c >= tedc_pkg::CH_0) && (c <= tedc_pkg::CH_9)) ||
		((c >= tedc_pkg::CH_LA) && (c <= tedc_pkg::CH_LF)) ||
		((c >= tedc_pkg::CH_UA) && (c <= tedc_pkg::CH_UF));
	// low nibble of a-f / A-F is 1..6, so +9 gives 10..15
	assign hexv = (c <= tedc_pkg::CH_9) ? c[3:0] : c[3:0] + 4'd9;

	always_comb begin
		nmode    = mode_q;
		nacc     = acc_q;
		nhl      = hl_q;
		pre_v    = 1'b0;
		pre_b    = 8'h00;
		do_plain = 1'b0;
		unique case (mode_q)
			tedc_pkg::M_ESC: begin
				nmode = tedc_pkg::M_NORMAL;
				if (c == tedc_pkg::CH_N) begin
					pre_v = 1'b1;
					pre_b = tedc_pkg::CH_NL;
				end else if (c == tedc_pkg::CH_BANG) begin
					nhl = ~hl_q;
				end else if (c == tedc_pkg::CH_QUOTE || c == tedc_pkg::CH_BSL) begin
					pre_v = 1'b1;
					pre_b = c | hl;
				end else if (c == tedc_pkg::CH_X) begin
					nacc  = 8'h00;
					nmode = tedc_pkg::M_HEX0;
				end else if (is_oct) begin
					nacc  = {5'b0, c[2:0]};
					nmode = tedc_pkg::M_OCT1;
				end else begin
					pre_v    = 1'b1;
					pre_b    = tedc_pkg::CH_BSL | hl;
					do_plain = 1'b1;
				end
			end
			tedc_pkg::M_HEX0: begin
				if (is_hex) begin
					nacc  = {4'b0, hexv};
					nmode = tedc_pkg::M_HEX1;
				end else begin
					pre_v    = 1'b1;
					pre_b    = acc_q;
					nmode    = tedc_pkg::M_NORMAL;
					do_plain = 1'b1;
				end
			end
			tedc_pkg::M_HEX1: begin
				pre_v = 1'b1;
				nmode = tedc_pkg::M_NORMAL;
				if (is_hex) begin
					pre_b = {acc_q[3:0], hexv};
				end else begin
					pre_b    = acc_q;
					do_plain = 1'b1;
				end
			end
			tedc_pkg::M_OCT1: begin
				if (is_oct) begin
					nacc  = {acc_q[4:0], c[2:0]};
					nmode = tedc_pkg::M_OCT2;
				end else begin
					pre_v    = 1'b1;
					pre_b    = acc_q;
					nmode    = tedc_pkg::M_NORMAL;
					do_plain = 1'b1;
				end
			end
			tedc_pkg::M_OCT2: begin
				pre_v = 1'b1;
				nmode = tedc_pkg::M_NORMAL;
				if (is_oct) begin
					pre_b = {acc_q[4:0], c[2:0]};
				end else begin
					pre_b    = acc_q;
					do_plain = 1'b1;
				end
			end
			default: begin
				nmode    = tedc_pkg::M_NORMAL;
				do_plain = 1'b1;
			end
		endcase

		plain_v = 1'b0;
		plain_b = c | hl;
		if (do_plain) begin
			if (c == tedc_pkg::CH_BSL) begin
				nmode = tedc_pkg::M_ESC;
			end else begin
				plain_v = 1'b1;
			end
		end

		// end of string resolves whatever escape is pending
		nhl_bits = nhl ? tedc_pkg::HL_BIT : 8'h00;
		end_v    = last && (nmode != tedc_pkg::M_NORMAL);
		end_b    = (nmode == tedc_pkg::M_ESC) ? (tedc_pkg::CH_BSL | nhl_bits) : nacc;

		np = 2'd0;
		b0 = 8'h00;
		b1 = 8'h00;
		if (pre_v) begin
			b0 = pre_b;
			np = 2'd1;
		end
		if (plain_v) begin
			if (np == 2'd0) begin
				b0 = plain_b;
			end else begin
				b1 = plain_b;
			end
			np = np + 2'd1;
		end
		if (end_v && np != 2'd2) begin
			if (np == 2'd0) begin
				b0 = end_b;
			end else begin
				b1 = end_b;
			end
			np = np + 2'd1;
		end
	end

	assign push         = accept && (np != 2'd0 || last);
	assign entry.nbytes = np;
	assign entry.byte0  = b0;
	assign entry.byte1  = b1;
	assign entry.last   = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= tedc_pkg::M_NORMAL;
			acc_q  <= 8'h00;
			hl_q   <= 1'b0;
		end else if (accept) begin
			if (last) begin
				mode_q <= tedc_pkg::M_NORMAL;
				acc_q  <= 8'h00;
				hl_q   <= 1'b0;
			end else begin
				mode_q <= nmode;
				acc_q  <= nacc;
				hl_q   <= nhl;
			end
		end
	end

endmodule

// ----- rtl/core/tedc_queue.sv -----
// Small entry queue between decoder and emitter.
module tedc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tedc_pkg::entry_t push_entry,
	input  logic             pop,
	output logic             full,
	output logic             head_valid,
	output tedc_pkg::entry_t head
);

	tedc_pkg::entry_t mem_q [tedc_pkg::QDEPTH];
	logic [tedc_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [tedc_pkg::QCNT_W-1:0] cnt_q;

	assign full       = (cnt_q == tedc_pkg::QCNT_W'(tedc_pkg::QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/tedc_back.sv -----
// Back end: applies the length limit and emits one result per cycle while result_stall is low.
module tedc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  tedc_pkg::entry_t    head,
	output logic                pop,
	output logic                result_valid,
	input  logic                result_stall,
	output tedc_pkg::out_item_t result
);

	logic [tedc_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic drop_q, drop_d;
	logic idx_q, idx_d;
	logic oval_q;
	tedc_pkg::out_item_t out_q, res;

	logic       go, ld, room, room2, item_drop;
	logic [1:0] kept;

	assign go    = head_valid && (!oval_q || !result_stall);
	assign room  = cnt_q < tedc_pkg::LIMIT;
	assign room2 = cnt_q < tedc_pkg::LIMIT_M1;

	// bytes of the head entry that still fit under the limit
	always_comb begin
		case (head.nbytes)
			2'd0:    kept = 2'd0;
			2'd1:    kept = room ? 2'd1 : 2'd0;
			default: kept = room2 ? 2'd2 : (room ? 2'd1 : 2'd0);
		endcase
	end

	assign item_drop = drop_q || ((head.nbytes != 2'd0) && !room) ||
		((head.nbytes == 2'd2) && !room2);

	always_comb begin
		pop    = 1'b0;
		ld     = 1'b0;
		res    = '0;
		cnt_d  = cnt_q;
		drop_d = drop_q;
		idx_d  = idx_q;
		if (go) begin
			if (!idx_q) begin
				drop_d = item_drop;
				if (kept == 2'd0) begin
					pop = 1'b1;
					if (head.last) begin
						ld                = 1'b1;
						res.final_result  = 1'b1;
						res.was_truncated = item_drop;
					end
				end else begin
					ld                = 1'b1;
					res.out_byte      = head.byte0;
					res.byte_valid    = 1'b1;
					res.final_result  = head.last && (kept == 2'd1);
					res.was_truncated = item_drop;
					cnt_d             = cnt_q + 1'b1;
					if (kept == 2'd1) begin
						pop = 1'b1;
					end else begin
						idx_d = 1'b1;
					end
				end
			end else begin
				ld                = 1'b1;
				res.out_byte      = head.byte1;
				res.byte_valid    = 1'b1;
				res.final_result  = head.last;
				res.was_truncated = drop_q;
				cnt_d             = cnt_q + 1'b1;
				pop               = 1'b1;
				idx_d             = 1'b0;
			end
			if (pop && head.last) begin
				cnt_d  = '0;
				drop_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			drop_q <= 1'b0;
			idx_q  <= 1'b0;
			oval_q <= 1'b0;
		end else begin
			cnt_q  <= cnt_d;
			drop_q <= drop_d;
			idx_q  <= idx_d;
			if (ld) begin
				oval_q <= 1'b1;
			end else if (!result_stall) begin
				oval_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			out_q <= res;
		end
	end

	assign result_valid = oval_q;
	assign result       = out_q;

endmodule

// ----- rtl/core/text_escape_decoder_core.sv -----
// Top level of the backslash-escape text decoder.
// Takes one text byte per cycle while item_stall is low. The decoder
// classifies each byte in the cycle it is accepted and writes up to two
// decoded bytes into a four-entry queue; the emitter drains the queue one
// result per cycle, while result_stall is low, into a registered output.
// The emitter sets the sustained rate: a request that yields two bytes
// holds it for two results, and the queue absorbs these until it fills,
// at which point item_stall rises. Up to MAX_LEN-1 bytes leave per string;
// the rest are dropped and flagged in was_truncated. A string always closes
// with a result marked final_result, a bare marker with byte_valid low if
// no byte was left to carry it.
module text_escape_decoder_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  tedc_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output tedc_pkg::out_item_t result
);

	logic             accept, push, pop, full, head_valid;
	tedc_pkg::entry_t entry, head;

	assign item_stall = full;
	assign accept     = item_valid && !full;

	tedc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.push   (push),
		.entry  (entry)
	);

	tedc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (entry),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head       (head)
	);

	tedc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
